/* hw/rtl/swt_pkg.sv */
`default_nettype none

package swt_pkg;

  // Field widths fixed by the sample and result formats.
  localparam int STAGE_W = 5;
  localparam int DATA_W  = 32;
  localparam int UNIT_W  = 8;
  localparam int PROD_W  = DATA_W + UNIT_W;

  // Default number of tracked stages.
  localparam int SWT_STAGE_COUNT = 19;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // Configuration register map.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_BYTES     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_STACK = 1'd1;

  localparam logic [UNIT_W-1:0] UNIT_BYTES_RST     = 8'd1;
  localparam logic [DATA_W-1:0] EXPECTED_STACK_RST = 32'd8192;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [DATA_W-1:0]  raw_mark;
    logic [DATA_W-1:0]  reported_size;
    logic [DATA_W-1:0]  task_identity;
  } swt_item_t;

  typedef struct packed {
    logic               accepted;
    logic [DATA_W-1:0]  scaled_bytes;
    logic [DATA_W-1:0]  stage_minimum;
    logic [DATA_W-1:0]  global_minimum;
    logic [STAGE_W-1:0] global_low_stage;
    logic               identity_mismatch;
    logic               size_mismatch;
    logic [DATA_W-1:0]  sample_count;
    logic               usable;
  } swt_result_t;

endpackage

`default_nettype wire

/* hw/rtl/swt_if.sv */
`default_nettype none

// Sample channel.
interface swt_in_if;
  logic                        valid;
  logic                        ready;
  logic [swt_pkg::STAGE_W-1:0] stage;
  logic [swt_pkg::DATA_W-1:0]  raw_mark;
  logic [swt_pkg::DATA_W-1:0]  reported_size;
  logic [swt_pkg::DATA_W-1:0]  task_identity;

  modport source (output valid, stage, raw_mark, reported_size,
                  task_identity, input ready);
  modport sink   (input valid, stage, raw_mark, reported_size,
                  task_identity, output ready);
endinterface

// Result channel.
interface swt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [swt_pkg::DATA_W-1:0]  scaled_bytes;
  logic [swt_pkg::DATA_W-1:0]  stage_minimum;
  logic [swt_pkg::DATA_W-1:0]  global_minimum;
  logic [swt_pkg::STAGE_W-1:0] global_low_stage;
  logic                        identity_mismatch;
  logic                        size_mismatch;
  logic [swt_pkg::DATA_W-1:0]  sample_count;
  logic                        usable;

  modport source (output valid, accepted, scaled_bytes, stage_minimum,
                  global_minimum, global_low_stage, identity_mismatch,
                  size_mismatch, sample_count, usable, input ready);
  modport sink   (input valid, accepted, scaled_bytes, stage_minimum,
                  global_minimum, global_low_stage, identity_mismatch,
                  size_mismatch, sample_count, usable, output ready);
endinterface

// Configuration write channel.
interface swt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swt_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [swt_pkg::DATA_W-1:0]      wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swt_scaler.sv */
`default_nettype none

// Scales a raw count to bytes and saturates at all ones.
module swt_scaler (
  input  wire logic [swt_pkg::DATA_W-1:0] raw,
  input  wire logic [swt_pkg::UNIT_W-1:0] unit,
  output logic      [swt_pkg::DATA_W-1:0] bytes
);

  logic [swt_pkg::PROD_W-1:0] product;

  assign product = swt_pkg::PROD_W'(raw) * swt_pkg::PROD_W'(unit);

  assign bytes = (|product[swt_pkg::PROD_W-1:swt_pkg::DATA_W]) ? swt_pkg::ALL_ONES
                                                               : product[swt_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/swt_tracker.sv */
`default_nettype none

// Holds the per-stage and global minima, the identity latch, the sticky
// flags and the sample counter, and forms the result for one sample.
module swt_tracker #(
  parameter int STAGE_COUNT = swt_pkg::SWT_STAGE_COUNT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       update,
  input  wire swt_pkg::swt_item_t         item,
  input  wire logic [swt_pkg::DATA_W-1:0] bytes,
  input  wire logic [swt_pkg::DATA_W-1:0] expected_stack,
  output swt_pkg::swt_result_t            result
);

  logic [swt_pkg::DATA_W-1:0]  low_r [STAGE_COUNT];
  logic [STAGE_COUNT-1:0]      seen_r;
  logic [STAGE_COUNT-1:0]      hit;
  logic [swt_pkg::DATA_W-1:0]  cur_low;
  logic [swt_pkg::DATA_W-1:0]  new_low;
  logic                        acc;
  logic                        fire;

  logic [swt_pkg::DATA_W-1:0]  overall_r,  overall_nxt;
  logic [swt_pkg::STAGE_W-1:0] ov_stage_r, ov_stage_nxt;
  logic [swt_pkg::DATA_W-1:0]  ident_r,    ident_nxt;
  logic                        id_flag_r,  id_flag_nxt;
  logic                        sz_flag_r,  sz_flag_nxt;
  logic [swt_pkg::DATA_W-1:0]  count_r,    count_nxt;

  assign acc  = (item.stage != '0) &&
                (item.stage <= swt_pkg::STAGE_W'(STAGE_COUNT));
  assign fire = update && acc;

  always_comb begin
    for (int i = 0; i < STAGE_COUNT; i++) begin
      hit[i] = (item.stage == swt_pkg::STAGE_W'(i + 1));
    end
  end

  // An entry never written reads as all ones.
  always_comb begin
    cur_low = swt_pkg::ALL_ONES;
    for (int i = 0; i < STAGE_COUNT; i++) begin
      if (hit[i] && seen_r[i]) begin
        cur_low = low_r[i];
      end
    end
  end

  assign new_low = (bytes < cur_low) ? bytes : cur_low;

  always_comb begin
    overall_nxt  = overall_r;
    ov_stage_nxt = ov_stage_r;
    ident_nxt    = ident_r;
    id_flag_nxt  = id_flag_r;
    sz_flag_nxt  = sz_flag_r;
    count_nxt    = count_r;
    if (acc) begin
      if (bytes < overall_r) begin
        overall_nxt  = bytes;
        ov_stage_nxt = item.stage;
      end
      if (ident_r == '0) begin
        ident_nxt = item.task_identity;
      end else if (item.task_identity != ident_r) begin
        id_flag_nxt = 1'b1;
      end
      if (item.reported_size != expected_stack) begin
        sz_flag_nxt = 1'b1;
      end
      count_nxt = count_r + swt_pkg::DATA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGE_COUNT; i++) begin
      if (fire && hit[i]) begin
        low_r[i] <= new_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      overall_r  <= swt_pkg::ALL_ONES;
      ov_stage_r <= '0;
      ident_r    <= '0;
      id_flag_r  <= 1'b0;
      sz_flag_r  <= 1'b0;
      count_r    <= '0;
    end else if (fire) begin
      seen_r     <= seen_r | hit;
      overall_r  <= overall_nxt;
      ov_stage_r <= ov_stage_nxt;
      ident_r    <= ident_nxt;
      id_flag_r  <= id_flag_nxt;
      sz_flag_r  <= sz_flag_nxt;
      count_r    <= count_nxt;
    end
  end

  always_comb begin
    result.accepted          = acc;
    result.scaled_bytes      = acc ? bytes : '0;
    result.stage_minimum     = acc ? new_low : '0;
    result.global_minimum    = overall_nxt;
    result.global_low_stage  = ov_stage_nxt;
    result.identity_mismatch = id_flag_nxt;
    result.size_mismatch     = sz_flag_nxt;
    result.sample_count      = count_nxt;
    result.usable            = (count_nxt != '0) && (overall_nxt != '0) &&
                               (overall_nxt != swt_pkg::ALL_ONES) &&
                               !id_flag_nxt && !sz_flag_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/stage_watermark_tracker.sv */
// A sample passes through the input register and then the result register before
// its result transaction can be taken; a stall on out_ch can hold it in either.
// Throughput: one sample per cycle while out_ch.ready holds; the input register,
// the scale-and-update step and the result register form a two-stage pipeline.
// Reset (rst_n, synchronous, active low) empties the pipeline, clears the minima,
// flags, identity latch and counter, and loads the register defaults.
`default_nettype none

module stage_watermark_tracker #(
  parameter int STAGE_COUNT = swt_pkg::SWT_STAGE_COUNT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  swt_in_if.sink    in_ch,
  swt_out_if.source out_ch,
  swt_cfg_if.sink   cfg_ch
);

  // Configuration registers. The user must write them only while the block is idle;
  // the block itself does not enforce this, and the port is always ready.
  logic [swt_pkg::UNIT_W-1:0] unit_r;
  logic [swt_pkg::DATA_W-1:0] expected_r;

  // Input register holding the sample transaction being processed.
  logic               s1_valid_r;
  swt_pkg::swt_item_t s1_item_r;

  // Result register; it holds a finished result until the sink takes it.
  logic                 out_valid_r;
  swt_pkg::swt_result_t out_res_r;

  logic                       advance;
  logic [swt_pkg::DATA_W-1:0] bytes;
  swt_pkg::swt_result_t       result;

  // The whole pipeline moves whenever the result register is free or is
  // being emptied in this cycle. A new sample can enter whenever the input
  // register is empty or moving on, so back-to-back samples need no gap.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r     <= swt_pkg::UNIT_BYTES_RST;
      expected_r <= swt_pkg::EXPECTED_STACK_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        swt_pkg::CFG_UNIT_BYTES:     unit_r     <= cfg_ch.wdata[swt_pkg::UNIT_W-1:0];
        swt_pkg::CFG_EXPECTED_STACK: expected_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.stage         <= in_ch.stage;
      s1_item_r.raw_mark      <= in_ch.raw_mark;
      s1_item_r.reported_size <= in_ch.reported_size;
      s1_item_r.task_identity <= in_ch.task_identity;
    end
  end

  // Raw count to bytes: one 32 by 8 multiply with saturation.
  swt_scaler u_scaler (
    .raw   (s1_item_r.raw_mark),
    .unit  (unit_r),
    .bytes (bytes)
  );

  // The state is updated at the edge where the sample leaves the input
  // register, so the next sample behind it already sees the new minima.
  swt_tracker #(
    .STAGE_COUNT (STAGE_COUNT)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .update         (s1_valid_r && advance),
    .item           (s1_item_r),
    .bytes          (bytes),
    .expected_stack (expected_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.accepted          = out_res_r.accepted;
  assign out_ch.scaled_bytes      = out_res_r.scaled_bytes;
  assign out_ch.stage_minimum     = out_res_r.stage_minimum;
  assign out_ch.global_minimum    = out_res_r.global_minimum;
  assign out_ch.global_low_stage  = out_res_r.global_low_stage;
  assign out_ch.identity_mismatch = out_res_r.identity_mismatch;
  assign out_ch.size_mismatch     = out_res_r.size_mismatch;
  assign out_ch.sample_count      = out_res_r.sample_count;
  assign out_ch.usable            = out_res_r.usable;

endmodule

`default_nettype wire
